FILE: rtl/core/e2rm_pkg.sv
// ----------------------------------------------------------------------------
// e2rm_pkg
// Shared types, constants and helper functions for the Euler-angle to
// rotation matrix block.
// ----------------------------------------------------------------------------
package e2rm_pkg;

   localparam int ANGLE_BITS  = 16;
   localparam int FRAC_BITS   = 14;
   localparam int TRIG_STAGES = 16;
   localparam int STAGE_BITS  = 5;
   localparam int Q_BITS      = FRAC_BITS + 2;
   localparam int CX_BITS     = 35;
   localparam int TURN_BITS   = 32;
   localparam int PROD_BITS   = 2 * Q_BITS + 2;
   localparam int SAT_BITS    = 40;

   localparam logic signed [Q_BITS-1:0]  ONE_Q     = Q_BITS'(1 << FRAC_BITS);
   localparam logic signed [CX_BITS-1:0] GAIN_INIT = CX_BITS'(64'd2608131496);

   typedef logic signed [Q_BITS-1:0]  q_type;
   typedef q_type [8:0]               mat_type;
   typedef logic signed [CX_BITS-1:0] cx_type;

   typedef struct packed {
      logic                       valid;
      logic [2:0]                 flip;
      cx_type [2:0]               x;
      cx_type [2:0]               y;
      logic [2:0][TURN_BITS-1:0]  z;
   } cordic_type;

   typedef enum logic [1:0] {
      KIND_EXT_ROT = 2'd0,
      KIND_INT_ROT = 2'd1,
      KIND_EXT_DCM = 2'd2,
      KIND_INT_DCM = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   localparam logic [3:0] ORDER_COUNT = 4'd12;
   localparam logic [7:0] REG_ORDER   = 8'd0;
   localparam logic [7:0] REG_KIND    = 8'd1;

   // atan(2^-i), full turn is 2^32
   function automatic logic [TURN_BITS-1:0] atan_lut(input logic [STAGE_BITS-1:0] idx);
      case (idx)
         5'd0:  atan_lut = 32'd536870912;
         5'd1:  atan_lut = 32'd316933406;
         5'd2:  atan_lut = 32'd167458907;
         5'd3:  atan_lut = 32'd85004756;
         5'd4:  atan_lut = 32'd42667331;
         5'd5:  atan_lut = 32'd21354465;
         5'd6:  atan_lut = 32'd10679838;
         5'd7:  atan_lut = 32'd5340245;
         5'd8:  atan_lut = 32'd2670163;
         5'd9:  atan_lut = 32'd1335087;
         5'd10: atan_lut = 32'd667544;
         5'd11: atan_lut = 32'd333772;
         5'd12: atan_lut = 32'd166886;
         5'd13: atan_lut = 32'd83443;
         5'd14: atan_lut = 32'd41722;
         5'd15: atan_lut = 32'd20861;
         5'd16: atan_lut = 32'd10430;
         5'd17: atan_lut = 32'd5215;
         5'd18: atan_lut = 32'd2608;
         5'd19: atan_lut = 32'd1304;
         5'd20: atan_lut = 32'd652;
         5'd21: atan_lut = 32'd326;
         5'd22: atan_lut = 32'd163;
         5'd23: atan_lut = 32'd81;
         5'd24: atan_lut = 32'd41;
         5'd25: atan_lut = 32'd20;
         5'd26: atan_lut = 32'd10;
         5'd27: atan_lut = 32'd5;
         5'd28: atan_lut = 32'd3;
         5'd29: atan_lut = 32'd1;
         5'd30: atan_lut = 32'd1;
         default: atan_lut = 32'd0;
      endcase
   endfunction

   // axis of position pos (0 first, 1 middle, 2 last) for an order code
   function automatic axis_type order_axis(input logic [3:0] order, input logic [1:0] pos);
      logic [5:0] trio;
      case (order)
         4'd0:  trio = {AXIS_X, AXIS_Y, AXIS_Z};
         4'd1:  trio = {AXIS_Y, AXIS_X, AXIS_Z};
         4'd2:  trio = {AXIS_X, AXIS_Z, AXIS_Y};
         4'd3:  trio = {AXIS_Z, AXIS_X, AXIS_Y};
         4'd4:  trio = {AXIS_Y, AXIS_Z, AXIS_X};
         4'd5:  trio = {AXIS_Z, AXIS_Y, AXIS_X};
         4'd6:  trio = {AXIS_Z, AXIS_Y, AXIS_Z};
         4'd7:  trio = {AXIS_Z, AXIS_X, AXIS_Z};
         4'd8:  trio = {AXIS_X, AXIS_Z, AXIS_X};
         4'd9:  trio = {AXIS_X, AXIS_Y, AXIS_X};
         4'd10: trio = {AXIS_Y, AXIS_Z, AXIS_Y};
         4'd11: trio = {AXIS_Y, AXIS_X, AXIS_Y};
         default: trio = {AXIS_X, AXIS_X, AXIS_X};
      endcase
      case (pos)
         2'd0:    order_axis = axis_type'(trio[1:0]);
         2'd1:    order_axis = axis_type'(trio[3:2]);
         default: order_axis = axis_type'(trio[5:4]);
      endcase
   endfunction

   function automatic q_type sat_one(input logic signed [SAT_BITS-1:0] v);
      if (v > SAT_BITS'(1 << FRAC_BITS))
         sat_one = ONE_Q;
      else if (v < -SAT_BITS'(1 << FRAC_BITS))
         sat_one = -ONE_Q;
      else
         sat_one = v[Q_BITS-1:0];
   endfunction

   function automatic mat_type elem_mat(input axis_type axis, input q_type s, input q_type c);
      mat_type m;
      m = '0;
      case (axis)
         AXIS_X: begin
            m[0] = ONE_Q; m[4] = c; m[5] = -s; m[7] = s; m[8] = c;
         end
         AXIS_Y: begin
            m[4] = ONE_Q; m[0] = c; m[2] = s; m[6] = -s; m[8] = c;
         end
         default: begin
            m[8] = ONE_Q; m[0] = c; m[1] = -s; m[3] = s; m[4] = c;
         end
      endcase
      elem_mat = m;
   endfunction

endpackage

FILE: rtl/core/euler_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// Three binary angles in, one saturated Q1.14 3x3 rotation matrix out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | three 16-bit angles
//  rsp     | out       | rsp_tvalid/rsp_tready | nine 16-bit matrix entries
//  csr     | in        | csr_valid/csr_ready   | register index, write data
//
//  One transfer per cycle while rsp is not stalled; 16 CORDIC cells, one
//  sine/cosine rounding stage, two matrix product cells, output register.
//  The CORDIC cell chain sets the latency; every stage advances together.
//  Reset clears the valid bits and the registers (order ZYX, extrinsic).
//  When rsp is stalled with a result waiting, the whole pipeline holds.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix import e2rm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // angle_first, angle_second, angle_third
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,   // m00 m01 m02 m10 m11 m12 m20 m21 m22
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [7:0]   csr_data
);

   logic [3:0] order_ff;
   kind_type   kind_ff;
   logic       advance;
   logic       negate;
   logic       transpose;

   cordic_type chain [TRIG_STAGES+1];

   logic          trig_valid_in, trig_valid_ff;
   q_type [2:0]   sin_in, cos_in, sin_ff, cos_ff;
   logic          mm1_valid, mm2_valid;
   mat_type       mm1_p, mm2_p;
   mat_type       rsp_in, rsp_ff;
   logic          rsp_valid_ff;

   // --- configuration registers --------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 4'd0;
         kind_ff  <= KIND_EXT_ROT;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_ORDER)
            order_ff <= csr_data[3:0];
         else if (csr_index == REG_KIND)
            kind_ff <= kind_type'(csr_data[1:0]);
      end
   end

   assign negate    = (kind_ff == KIND_INT_ROT) || (kind_ff == KIND_INT_DCM);
   assign transpose = (kind_ff == KIND_INT_ROT) || (kind_ff == KIND_EXT_DCM);

   // hold every stage while a result waits untaken
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // --- angle fold into the CORDIC range ------------------------------------
   always_comb begin
      logic [TURN_BITS-1:0] ang;
      chain[0].valid = req_tvalid;
      for (int k = 0; k < 3; k++) begin
         ang = {req_tdata[k*ANGLE_BITS +: ANGLE_BITS], (TURN_BITS-ANGLE_BITS)'(0)};
         if (negate)
            ang = TURN_BITS'(0) - ang;
         // second and third quadrants: rotate by half a turn, negate later
         chain[0].flip[k] = ang[TURN_BITS-1] ^ ang[TURN_BITS-2];
         chain[0].z[k]    = chain[0].flip[k] ? (ang ^ {1'b1, (TURN_BITS-1)'(0)}) : ang;
         chain[0].x[k]    = GAIN_INIT;
         chain[0].y[k]    = '0;
      end
   end

   // --- CORDIC cell chain ----------------------------------------------------
   for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
      e2rm_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_idx (STAGE_BITS'(g)),
         .cell_in   (chain[g]),
         .cell_out  (chain[g+1])
      );
   end

   // --- round to Q1.14, undo the fold, saturate -----------------------------
   always_comb begin
      cx_type rc, rs;
      trig_valid_in = chain[TRIG_STAGES].valid;
      for (int k = 0; k < 3; k++) begin
         rc = ($signed(chain[TRIG_STAGES].x[k]) + CX_BITS'(1 << (31 - FRAC_BITS)))
              >>> (32 - FRAC_BITS);
         rs = ($signed(chain[TRIG_STAGES].y[k]) + CX_BITS'(1 << (31 - FRAC_BITS)))
              >>> (32 - FRAC_BITS);
         if (chain[TRIG_STAGES].flip[k]) begin
            rc = -rc;
            rs = -rs;
         end
         cos_in[k] = sat_one(SAT_BITS'(rc));
         sin_in[k] = sat_one(SAT_BITS'(rs));
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         trig_valid_ff <= 1'b0;
      else if (advance)
         trig_valid_ff <= trig_valid_in;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   // --- products: middle * first, then last * that -------------------------
   // third angle's sine/cosine are delayed one stage to meet the first product
   q_type s2_d_ff, c2_d_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_d_ff <= sin_ff[2];
         c2_d_ff <= cos_ff[2];
      end
   end

   e2rm_matmul_cell u_mm1 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (trig_valid_ff),
      .mat_a     (elem_mat(order_axis(order_ff, 2'd1), sin_ff[1], cos_ff[1])),
      .mat_b     (elem_mat(order_axis(order_ff, 2'd0), sin_ff[0], cos_ff[0])),
      .out_valid (mm1_valid),
      .mat_p     (mm1_p)
   );

   e2rm_matmul_cell u_mm2 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (mm1_valid),
      .mat_a     (elem_mat(order_axis(order_ff, 2'd2), s2_d_ff, c2_d_ff)),
      .mat_b     (mm1_p),
      .out_valid (mm2_valid),
      .mat_p     (mm2_p)
   );

   // --- unused orders give identity; transpose for ext. DCM/int. rotation ---
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (order_ff >= ORDER_COUNT)
               rsp_in[i*3+j] = (i == j) ? ONE_Q : q_type'(0);
            else if (transpose)
               rsp_in[i*3+j] = mm2_p[j*3+i];
            else
               rsp_in[i*3+j] = mm2_p[i*3+j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (advance)
         rsp_valid_ff <= mm2_valid;
   end

   always_ff @(posedge clock) begin
      if (advance)
         rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // --- checks --------------------------------------------------------------
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_ff[0]) <= $signed(ONE_Q)) &&
                     ($signed(rsp_ff[0]) >= -$signed(ONE_Q)) &&
                     ($signed(rsp_ff[8]) <= $signed(ONE_Q)) &&
                     ($signed(rsp_ff[8]) >= -$signed(ONE_Q)))
      else $error("matrix entry outside +/-1.0");

   a_order_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index == REG_ORDER) |=> order_ff == $past(csr_data[3:0]))
      else $error("order register missed a write");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(mm2_p) && $stable(trig_valid_ff))
      else $error("pipeline moved while output stalled");

endmodule

FILE: rtl/core/e2rm_cordic_cell.sv
// ----------------------------------------------------------------------------
// e2rm_cordic_cell
// One rotation-mode CORDIC step for all three angles, registered.
// ----------------------------------------------------------------------------
module e2rm_cordic_cell import e2rm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [STAGE_BITS-1:0] stage_idx,
   input  cordic_type            cell_in,
   output cordic_type            cell_out
);

   cordic_type cell_in_c;
   cordic_type cell_ff;

   always_comb begin
      cx_type dx;
      cx_type dy;
      cell_in_c = cell_in;
      for (int k = 0; k < 3; k++) begin
         dx = $signed(cell_in.y[k]) >>> stage_idx;
         dy = $signed(cell_in.x[k]) >>> stage_idx;
         if (!cell_in.z[k][TURN_BITS-1]) begin
            cell_in_c.x[k] = $signed(cell_in.x[k]) - dx;
            cell_in_c.y[k] = $signed(cell_in.y[k]) + dy;
            cell_in_c.z[k] = cell_in.z[k] - atan_lut(stage_idx);
         end else begin
            cell_in_c.x[k] = $signed(cell_in.x[k]) + dx;
            cell_in_c.y[k] = $signed(cell_in.y[k]) - dy;
            cell_in_c.z[k] = cell_in.z[k] + atan_lut(stage_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance)
         cell_ff <= cell_in_c;
      if (reset)
         cell_ff.valid <= 1'b0;
   end

   assign cell_out = cell_ff;

endmodule

FILE: rtl/core/e2rm_matmul_cell.sv
// ----------------------------------------------------------------------------
// e2rm_matmul_cell
// Registered 3x3 Q1.14 product with round-half-up and saturation.
// ----------------------------------------------------------------------------
module e2rm_matmul_cell import e2rm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    in_valid,
   input  mat_type mat_a,
   input  mat_type mat_b,
   output logic    out_valid,
   output mat_type mat_p
);

   mat_type prod_in;
   mat_type prod_ff;
   logic    valid_ff;

   always_comb begin
      logic signed [PROD_BITS-1:0] acc;
      logic signed [PROD_BITS-1:0] rnd;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            acc = $signed(mat_a[i*3+0]) * $signed(mat_b[0+j])
                + $signed(mat_a[i*3+1]) * $signed(mat_b[3+j])
                + $signed(mat_a[i*3+2]) * $signed(mat_b[6+j]);
            rnd = (acc + PROD_BITS'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
            prod_in[i*3+j] = sat_one(SAT_BITS'(rnd));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else if (advance)
         valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (advance)
         prod_ff <= prod_in;
   end

   assign out_valid = valid_ff;
   assign mat_p     = prod_ff;

endmodule
